>>> hw/rtl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// No dependencies.
package bpa_pkg;

	localparam int unsigned WORD_W = 64;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_RANGE    = 2'd2
	} status_e;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_e;

	localparam logic CFG_REGION_BASE   = 1'b0;
	localparam logic CFG_PAGES_MANAGED = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [12:0] npages;
		logic [31:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [31:0] alloc_addr;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_DONE
	} state_e;

endpackage

>>> hw/rtl/bpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bpa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/bitmap_page_allocator.sv
// Bitmap page allocator: first-fit run search over a used-page bitmap RAM, a page at a time.
// A request rejected at once skips the search and goes straight to the result state; a free
// clears its pages, and an allocate scans for a run, then marks it, or reports no space.
// Throughput: one request at a time; the next is taken at the edge after the result register
// loads, and a result held under stall lets the next request run but not load.
// Reset: asynchronous, active low; then a clearing pass that zeroes every word of the bitmap RAM.
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int unsigned MAX_PAGES  = 4096,
	parameter int unsigned PAGE_SHIFT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int unsigned WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned PW    = $clog2(MAX_PAGES) + 1;
	localparam int unsigned BW    = $clog2(WORD_W);

	state_e state_q, state_d;

	logic [31:0] region_base_q;
	logic [12:0] pages_managed_q;
	logic        req_type_q;
	logic [PW:0] count_q;
	logic [PW:0] idx_q;     // current page
	logic [PW:0] start_q;   // run start
	logic [PW:0] run_q;
	logic [PW:0] left_q;    // pages still to write
	logic        rd_pend_q; // read data for idx_q valid this cycle
	logic [AW-1:0] clr_q;
	logic [31:0] res_addr_q;
	status_e     res_status_q;
	logic        out_valid_q;
	rsp_t        out_q;

	logic [PW:0] limit;
	logic [WORD_W-1:0] rdata, wdata;
	logic we;
	logic [AW-1:0] waddr, raddr;

	// effective limit: pages_managed clamped to MAX_PAGES
	always_comb begin
		if (32'(pages_managed_q) > MAX_PAGES)
			limit = (PW+1)'(MAX_PAGES);
		else
			limit = (PW+1)'(pages_managed_q);
	end

	bpa_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [AW-1:0] idx_word;
	logic [BW-1:0] idx_bit;
	logic          cur_bit;
	assign idx_word = AW'(idx_q >> BW);
	assign idx_bit  = idx_q[BW-1:0];
	assign raddr    = idx_word;
	assign cur_bit  = rdata[idx_bit];

	logic in_fire, out_fire;
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_fire  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// free request index and range check
	logic [31:0] off;
	logic [31:0] fidx;
	logic [33:0] fend;
	assign off  = in_data.free_addr - region_base_q;
	assign fidx = off >> PAGE_SHIFT;
	assign fend = {2'b0, fidx} + 34'(in_data.npages);

	// request checks and run search terms
	logic        alloc_bad, free_bad, scan_end, run_hit, out_free;
	logic [PW:0] run_next, run_start;
	assign alloc_bad = (in_data.npages == '0) || (32'(in_data.npages) > 32'(limit));
	assign free_bad  = (fend > 34'(limit));
	assign scan_end  = !rd_pend_q && (idx_q >= limit);
	assign run_next  = run_q + 1'b1;
	assign run_start = (run_q == '0) ? idx_q : start_q;
	assign run_hit   = rd_pend_q && !cur_bit && (run_next == count_q);
	assign out_free  = !out_valid_q || out_fire;

	// writes: clearing pass, or read-modify-write of one bit in S_MARK
	always_comb begin
		we    = 1'b0;
		waddr = idx_word;
		wdata = rdata;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == S_MARK && rd_pend_q) begin
			we = 1'b1;
			wdata[idx_bit] = (req_type_q == REQ_ALLOC);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == AW'(WORDS - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (in_fire) begin
					if (in_data.req_type == REQ_ALLOC)
						state_d = alloc_bad ? S_DONE : S_SCAN;
					else if (in_data.npages == '0 || free_bad)
						state_d = S_DONE;
					else
						state_d = S_MARK;
				end
			end
			S_SCAN: begin
				if (scan_end) state_d = S_DONE;
				else if (run_hit) state_d = S_MARK;
			end
			S_MARK: if (rd_pend_q && left_q == (PW+1)'(1)) state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q           <= '0;
			region_base_q   <= 32'h0010_0000;
			pages_managed_q <= 13'd4096;
			req_type_q      <= 1'b0;
			count_q         <= '0;
			idx_q           <= '0;
			start_q         <= '0;
			run_q           <= '0;
			left_q          <= '0;
			rd_pend_q       <= 1'b0;
			res_addr_q      <= '0;
			res_status_q    <= ST_OK;
			out_valid_q     <= 1'b0;
			out_q           <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_REGION_BASE)
					region_base_q <= cfg_data;
				else
					pages_managed_q <= cfg_data[12:0];
			end
			// result register loads only once the previous result is gone
			if (state_q == S_DONE && out_free) begin
				out_valid_q      <= 1'b1;
				out_q.alloc_addr <= res_addr_q;
				out_q.status     <= res_status_q;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + 1'b1;
				S_IDLE: if (in_fire) begin
					req_type_q <= in_data.req_type;
					count_q    <= (PW+1)'(in_data.npages);
					left_q     <= (PW+1)'(in_data.npages);
					rd_pend_q  <= 1'b0;
					run_q      <= '0;
					idx_q      <= (in_data.req_type == REQ_FREE) ? (PW+1)'(fidx) : '0;
					res_addr_q <= '0;
					if (in_data.req_type == REQ_ALLOC && alloc_bad)
						res_status_q <= ST_NO_SPACE;
					else if (in_data.req_type == REQ_FREE && in_data.npages != '0 &&
					         free_bad)
						res_status_q <= ST_RANGE;
					else
						res_status_q <= ST_OK;
				end
				// one page at a time: issue read, then check bit
				S_SCAN: begin
					if (!rd_pend_q) begin
						if (scan_end)
							res_status_q <= ST_NO_SPACE;
						else
							rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (run_hit) begin
							idx_q      <= run_start;
							left_q     <= count_q;
							res_addr_q <= region_base_q + (32'(run_start) << PAGE_SHIFT);
						end else begin
							idx_q <= idx_q + 1'b1;
							if (cur_bit) run_q <= '0;
							else begin
								if (run_q == '0) start_q <= idx_q;
								run_q <= run_next;
							end
						end
					end
				end
				// read-modify-write one page bit at a time: issue read, then write
				S_MARK: begin
					if (!rd_pend_q) rd_pend_q <= 1'b1;
					else begin
						rd_pend_q <= 1'b0;
						idx_q     <= idx_q + 1'b1;
						left_q    <= left_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

>>> hw/rtl/bpa_checker.sv
// Port-level checker for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg.
module bpa_props
	import bpa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input rsp_t out_data
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// status never takes an unused code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status");

	// failures report address zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.alloc_addr == '0)
		else $error("failure with nonzero address");

	// a transfer in is not followed by a result in the next cycle
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result too early");
endmodule

bind bitmap_page_allocator bpa_props u_bpa_props (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

>>> bench/bpa_checker.sv
// Checker for the bitmap page allocator: watches the request, response and
// register channels, predicts every response and compares. Depends on bpa_pkg.
`timescale 1ns / 100ps
module bpa_checker
	import bpa_pkg::*;
#(
	parameter int unsigned MAX_PAGES  = 4096,
	parameter int unsigned PAGE_SHIFT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  req_t        in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  rsp_t        out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          rsp_pending
);

	// shadow of the allocator state
	bit [MAX_PAGES-1:0] page_used = '0;
	logic [31:0]        base_addr = 32'h0010_0000;
	logic [12:0]        page_limit = 13'd4096;
	rsp_t               rsp_fifo[$];
	int                 n_fail = 0;
	int                 n_pending = 0;

	assign fail_count  = n_fail;
	assign rsp_pending = n_pending;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
		n_fail++;
	endtask

	// first-fit allocate / run free, as the block should do it
	task automatic predict_rsp(input req_t r, output rsp_t res);
		int unsigned n, i, start, run, cnt, idx;
		logic [31:0] off;
		bit found;
		n = (page_limit > MAX_PAGES) ? MAX_PAGES : page_limit;
		cnt = r.npages;
		res.alloc_addr = '0;
		res.status = ST_OK;
		found = 0;
		start = 0;
		run = 0;
		if (r.req_type == REQ_ALLOC) begin
			if (cnt != 0 && cnt <= n) begin
				for (i = 0; i < n && !found; i++) begin
					if (page_used[i]) begin
						run = 0;
					end else begin
						if (run == 0) start = i;
						run++;
						if (run == cnt) found = 1;
					end
				end
			end
			if (found) begin
				for (i = 0; i < cnt; i++) page_used[start + i] = 1'b1;
				res.alloc_addr = base_addr + (32'(start) << PAGE_SHIFT);
			end else begin
				res.status = ST_NO_SPACE;
			end
		end else begin
			off = r.free_addr - base_addr;
			idx = off >> PAGE_SHIFT;
			if (cnt != 0) begin
				if (64'(idx) + cnt > n) begin
					res.status = ST_RANGE;
				end else begin
					for (i = 0; i < cnt; i++) page_used[idx + i] = 1'b0;
				end
			end
		end
	endtask

	// sample all three channels at the edge
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_REGION_BASE) base_addr = cfg_data;
				else page_limit = cfg_data[12:0];
			end
			if (in_valid && !in_stall) begin
				predict_rsp(in_data, exp_rsp);
				rsp_fifo.push_back(exp_rsp);
			end
			if (out_valid && !out_stall) begin
				if (rsp_fifo.size() == 0) begin
					report_mismatch("unexpected response", out_data.alloc_addr, 32'h0);
				end else begin
					exp_rsp = rsp_fifo.pop_front();
					if (out_data.alloc_addr !== exp_rsp.alloc_addr)
						report_mismatch("alloc_addr", out_data.alloc_addr,
							exp_rsp.alloc_addr);
					if (out_data.status !== exp_rsp.status)
						report_mismatch("status", 32'(out_data.status),
							32'(exp_rsp.status));
				end
			end
			n_pending = rsp_fifo.size();
		end
	end

endmodule

>>> bench/tb_bitmap_page_allocator.sv
// Top of the page allocator bench: clock, reset, request and register stimulus,
// response back-pressure and the verdict. Depends on bpa_pkg, bitmap_page_allocator and bpa_checker.
`timescale 1ns / 100ps
module tb_bitmap_page_allocator;
	import bpa_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	req_t        in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	rsp_t        out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	int          fail_count;
	int          rsp_pending;
	bit          hold_req = 0;
	logic [31:0] cur_base = 32'h0010_0000;
	int unsigned cur_pages = 4096;

	always #5 clk = ~clk;

	bitmap_page_allocator dut (.*);

	bpa_checker chk (.*);

	// response side: random stalls, one long hold-off on request
	initial begin
		int n;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				held = 1;
				out_stall <= 1'b1;
				for (n = 0; n < 400; n++) @(posedge clk);
			end
			if ($urandom_range(0, 99) < 70) begin
				out_stall <= 1'b0;
				n = $urandom_range(1, 30);
			end else begin
				out_stall <= 1'b1;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
			end
			repeat (n) @(posedge clk);
		end
	end

	// one request transfer; valid stays high for a following send
	task automatic send_req(input req_e kind, input int unsigned cnt, input logic [31:0] addr);
		in_valid <= 1'b1;
		in_data <= '{req_type: kind, npages: 13'(cnt), free_addr: addr};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 50) return;
		n = (n < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (rsp_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_REGION_BASE) cur_base = val;
		else cur_pages = val[12:0];
	endtask

	// mostly well-formed allocate/free traffic sized to the managed range
	task automatic random_req();
		int unsigned eff, r, idx;
		eff = (cur_pages > 4096) ? 4096 : cur_pages;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			send_req(REQ_ALLOC, $urandom_range(1, (eff > 6) ? eff / 6 : 2), '0);
		end else if (r < 82 && eff > 0) begin
			idx = $urandom_range(0, eff - 1);
			send_req(REQ_FREE, $urandom_range(1, 8),
				cur_base + (32'(idx) << 12) + $urandom_range(0, 4095));
		end else if (r < 92) begin
			send_req(REQ_FREE, $urandom_range(0, 8191), $urandom());
		end else begin
			send_req(REQ_ALLOC, $urandom_range(0, 8191), $urandom());
		end
	endtask

	initial begin
		int p, k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and corner cases at reset settings, then with a high base and 64, then 0 pages
		send_req(REQ_ALLOC, 0, '0);
		send_req(REQ_ALLOC, 1, '0);
		send_req(REQ_ALLOC, 4096, '0);
		send_req(REQ_FREE, 1, 32'h0010_0000);
		send_req(REQ_ALLOC, 4096, '0);
		send_req(REQ_ALLOC, 1, '0);
		send_req(REQ_FREE, 4096, 32'h0010_0FFF);
		send_req(REQ_FREE, 8191, 32'h0010_0000);
		send_req(REQ_FREE, 1, 32'h0000_0000);
		send_req(REQ_FREE, 0, 32'h0010_0000);
		send_req(REQ_FREE, 3, 32'h0010_5000);
		send_req(REQ_ALLOC, 3, '0);
		send_req(REQ_ALLOC, 2, '0);
		send_req(REQ_FREE, 1, 32'h0010_1000);
		send_req(REQ_ALLOC, 2, '0);
		send_req(REQ_ALLOC, 1, '0);
		send_req(REQ_FREE, 1, 32'hFFFF_FFFF);
		write_reg(CFG_REGION_BASE, 32'hFFFF_F000);
		write_reg(CFG_PAGES_MANAGED, 32'd64);
		send_req(REQ_ALLOC, 2, '0);
		send_req(REQ_ALLOC, 65, '0);
		send_req(REQ_FREE, 64, 32'hFFFF_F000);
		write_reg(CFG_PAGES_MANAGED, 32'd0);
		send_req(REQ_ALLOC, 1, '0);
		send_req(REQ_FREE, 0, 32'h1234_5678);
		send_req(REQ_FREE, 1, 32'hFFFF_F000);

		// random phases over several register settings
		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin write_reg(CFG_REGION_BASE, 32'h0); write_reg(CFG_PAGES_MANAGED, 64); end
				1: begin write_reg(CFG_REGION_BASE, $urandom()); write_reg(CFG_PAGES_MANAGED, 200); end
				2: begin write_reg(CFG_REGION_BASE, 32'hFFFF_FFFF); write_reg(CFG_PAGES_MANAGED, 100); end
				3: begin write_reg(CFG_REGION_BASE, $urandom()); write_reg(CFG_PAGES_MANAGED, 1); end
				4: begin write_reg(CFG_REGION_BASE, $urandom()); write_reg(CFG_PAGES_MANAGED, 8191); end
				default: begin write_reg(CFG_REGION_BASE, $urandom()); write_reg(CFG_PAGES_MANAGED, 37); end
			endcase
			if (p == 0) hold_req = 1;
			for (k = 0; k < ((p == 4) ? 15 : 77); k++) begin
				random_req();
				send_gap();
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && rsp_pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// overall watchdog
	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
